/* src/smph_pkg.sv */
`default_nettype none

package smph_pkg;

  // Identifier bytes that open every packet, and the frame permission table.
  localparam int ID_BYTES    = 8;
  localparam int FRAME_COUNT = 16;
  localparam int FIRST_FRAME = 0;

  // Position counter width and its saturation value.
  localparam int          POS_W   = 8;
  localparam logic [7:0]  POS_MAX = 8'hFF;

  // Packet types.
  localparam logic [7:0] TYPE_PING   = 8'hFE;
  localparam logic [7:0] TYPE_CONFIG = 8'hD0;

  // Marker byte meaning "all samples" or "all frames".
  localparam logic [7:0] ALL_MARK = 8'hFF;

  // Number of sample bits held per frame.
  localparam int SAMPLE_BITS = 8;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [0:0] {
    REG_SENSOR_ID = 1'b0
  } reg_index_t;

  typedef enum logic [0:0] {
    ACT_BYTE  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_MASK  = 2'd2
  } result_kind_t;

  // One-hot bit for a sample number; samples of 8 or more give no bit.
  function automatic logic [7:0] sample_bit(input logic [7:0] s);
    logic [7:0] bit_v;
    bit_v = '0;
    if (int'(s) < SAMPLE_BITS) begin
      bit_v = 8'd1 << s[2:0];
    end
    return bit_v;
  endfunction

endpackage

`default_nettype wire

/* src/smph_if.sv */
`default_nettype none

// Input channel: one packet byte or one table query per item.
interface smph_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] action;
  logic [7:0] packet_type;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [3:0] frame_index;

  modport source (
    output valid, action, packet_type, data_byte, last_byte, frame_index,
    input  ready
  );
  modport sink (
    input  valid, action, packet_type, data_byte, last_byte, frame_index,
    output ready
  );
endinterface

// Result channel: echoed bytes, empty replies and frame masks.
interface smph_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] reply_byte;
  logic       reply_last;
  logic [7:0] frame_mask;

  modport source (
    output valid, result_kind, reply_byte, reply_last, frame_mask,
    input  ready
  );
  modport sink (
    input  valid, result_kind, reply_byte, reply_last, frame_mask,
    output ready
  );
endinterface

`default_nettype wire

/* src/sensor_maintenance_packet_handler.sv */
// Sensor maintenance packet handler. Packet bytes arrive one item at a time on
// in_ch, each tagged with its packet type; the first ID_BYTES bytes must equal
// the sensor identifier written at register 0 (byte 0 in bits 7:0), otherwise
// the rest of the packet is dropped. Ping payload bytes are echoed on out_ch,
// and a ping with no payload gives one empty-reply item. A config packet
// clears the 16-entry frame permission table and then applies (sample, frame)
// byte pairs to it. A query item returns one table entry as a frame mask.
// Every item is handled as it is accepted: the packet state and table are
// updated at the accepting edge and any result lands in the output register,
// so one item is accepted in every cycle while out_ch keeps taking results.
// The output register is the only buffering, so a stalled out_ch stops
// input acceptance after one held result. There is no clearing pass after
// reset; the table flip-flops clear at once.
`default_nettype none

module sensor_maintenance_packet_handler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  smph_in_if.sink                             in_ch,
  smph_out_if.source                          out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [smph_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [smph_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [smph_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import smph_pkg::*;

  // The register index is the address divided by the 8-byte stride.
  localparam int REG_LSB = 3;

  // Configuration register.
  logic [CFG_DATA_W-1:0] sensor_id_r;

  // Packet state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             id_match_r, id_match_nxt;
  logic [7:0]       held_sample_r, held_sample_nxt;
  logic             cfg_done_r, cfg_done_nxt;

  // Frame permission table, one flip-flop row per frame.
  logic [7:0] perm_r   [FRAME_COUNT];
  logic [7:0] perm_nxt [FRAME_COUNT];

  // Output register.
  logic         out_valid_r, out_valid_nxt;
  result_kind_t out_kind_r, out_kind_nxt;
  logic [7:0]   out_byte_r, out_byte_nxt;
  logic         out_last_r, out_last_nxt;
  logic [7:0]   out_mask_r, out_mask_nxt;

  logic       in_accept;
  logic       cfg_write;
  reg_index_t cfg_reg;
  logic [7:0] want_byte;
  logic       byte_ok;
  logic       odd_offset;
  logic       in_range;
  int         frame_off;
  logic [7:0] new_bit;

  // ---------------------------------------------------------------------------
  // Configuration port. pready is tied high, so no access is ever extended
  // by wait states after its setup phase.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_reg   = reg_index_t'(paddr[REG_LSB]);
  assign cfg_write = psel && penable && pwrite && pready && (cfg_reg == REG_SENSOR_ID);

  always_comb begin
    prdata = '0;
    if (cfg_reg == REG_SENSOR_ID) begin
      prdata = sensor_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_id_r <= '0;
    end else if (cfg_write) begin
      sensor_id_r <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. A new item is taken whenever the output register is empty or
  // its item is being taken in the same cycle.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Identifier byte expected at the current position; only meaningful while
  // the position is below ID_BYTES. The select uses the low three position bits, so it stays inside the word.
  assign want_byte  = sensor_id_r[8*int'(pos_r[2:0]) +: 8];
  assign byte_ok    = (in_ch.data_byte == want_byte);

  // Parity of the offset into the payload, without a subtraction.
  assign odd_offset = pos_r[0] ^ ID_BYTES[0];

  // Frame byte decoded against the table window.
  assign frame_off  = int'(in_ch.data_byte) - FIRST_FRAME;
  assign in_range   = (frame_off >= 0) && (frame_off < FRAME_COUNT);
  assign new_bit    = sample_bit(held_sample_r);

  // ---------------------------------------------------------------------------
  // Item processing: packet state, table update and the result, all in one
  // pass.
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_nxt         = pos_r;
    id_match_nxt    = id_match_r;
    held_sample_nxt = held_sample_r;
    cfg_done_nxt    = cfg_done_r;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      perm_nxt[i] = perm_r[i];
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_mask_nxt  = out_mask_r;

    if (in_accept) begin
      out_kind_nxt = KIND_ECHO;
      out_byte_nxt = '0;
      out_last_nxt = 1'b0;
      out_mask_nxt = '0;

      if (action_t'(in_ch.action) == ACT_QUERY) begin
        // A query reads one entry and leaves the packet state alone; an index
        // beyond the table reads as zero.
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_MASK;
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (int'(in_ch.frame_index) == i) begin
            out_mask_nxt = perm_r[i];
          end
        end
      end else begin
        if (pos_r != POS_MAX) begin
          if (int'(pos_r) < ID_BYTES) begin
            // Identifier phase: any mismatching byte spoils the packet.
            id_match_nxt = id_match_r && byte_ok;
            if ((int'(pos_r) == ID_BYTES - 1) && id_match_nxt) begin
              if (in_ch.packet_type == TYPE_CONFIG) begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                  perm_nxt[i] = '0;
                end
              end else if ((in_ch.packet_type == TYPE_PING) && in_ch.last_byte) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_EMPTY;
              end
            end
          end else if (id_match_r) begin
            if (in_ch.packet_type == TYPE_PING) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ECHO;
              out_byte_nxt  = in_ch.data_byte;
              out_last_nxt  = in_ch.last_byte;
            end else if ((in_ch.packet_type == TYPE_CONFIG) && !cfg_done_r) begin
              if (!odd_offset) begin
                // Sample byte of a pair; held until its frame byte arrives.
                held_sample_nxt = in_ch.data_byte;
              end else if ((held_sample_r == ALL_MARK) &&
                           (in_ch.data_byte == ALL_MARK)) begin
                // Grant everything and ignore the rest of the packet.
                for (int i = 0; i < FRAME_COUNT; i++) begin
                  perm_nxt[i] = '1;
                end
                cfg_done_nxt = 1'b1;
              end else if (held_sample_r == ALL_MARK) begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                  if (in_range && (frame_off == i)) begin
                    perm_nxt[i] = '1;
                  end
                end
              end else if (in_ch.data_byte == ALL_MARK) begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                  perm_nxt[i] = perm_r[i] | new_bit;
                end
              end else begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                  if (in_range && (frame_off == i)) begin
                    perm_nxt[i] = perm_r[i] | new_bit;
                  end
                end
              end
            end
          end
          pos_nxt = pos_r + 1'b1;
        end

        // The final byte always ends the packet, even past saturation.
        if (in_ch.last_byte) begin
          pos_nxt      = '0;
          id_match_nxt = 1'b1;
          cfg_done_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      id_match_r    <= 1'b1;
      held_sample_r <= '0;
      cfg_done_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        perm_r[i] <= '0;
      end
    end else begin
      pos_r         <= pos_nxt;
      id_match_r    <= id_match_nxt;
      held_sample_r <= held_sample_nxt;
      cfg_done_r    <= cfg_done_nxt;
      out_valid_r   <= out_valid_nxt;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        perm_r[i] <= perm_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.reply_byte  = out_byte_r;
  assign out_ch.reply_last  = out_last_r;
  assign out_ch.frame_mask  = out_mask_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // At the start of a packet the identifier has not yet been spoilt.
  a_start_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> id_match_r)
    else $error("identifier mismatch flag set at packet start");

  // The final byte of a packet always returns the position to zero and clears the config-done flag.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (action_t'(in_ch.action) == ACT_BYTE) && in_ch.last_byte)
      |=> (pos_r == '0) && !cfg_done_r)
    else $error("packet state not cleared after final byte");

  // A query always produces a frame mask item in the next cycle.
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (action_t'(in_ch.action) == ACT_QUERY))
      |=> out_valid_r && (out_kind_r == KIND_MASK))
    else $error("query did not yield a frame mask item");

  // Fields that do not belong to the result kind are zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_kind_r == KIND_MASK) || (out_mask_r == '0)) &&
      ((out_kind_r == KIND_ECHO) || ((out_byte_r == '0) && !out_last_r)))
    else $error("result carries stray field bits");

endmodule

`default_nettype wire
